// ===== hdl/lrubc_pkg.sv =====
package lrubc_pkg;

   localparam logic CMD_PUT = 1'b1;

   localparam logic [3:0] ST_HIT       = 4'd0;
   localparam logic [3:0] ST_FILLED    = 4'd1;
   localparam logic [3:0] ST_ZERO      = 4'd2;
   localparam logic [3:0] ST_UNMAPPED  = 4'd3;
   localparam logic [3:0] ST_EXHAUSTED = 4'd4;
   localparam logic [3:0] ST_IDLE      = 4'd5;
   localparam logic [3:0] ST_HELD      = 4'd6;
   localparam logic [3:0] ST_BADREL    = 4'd7;
   localparam logic [3:0] ST_REFFULL   = 4'd8;

   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;
   localparam logic [3:0] OP_SCAN      = 4'd2;
   localparam logic [3:0] OP_HIT_DONE  = 4'd3;
   localparam logic [3:0] OP_MISS_DONE = 4'd4;
   localparam logic [3:0] OP_EV_SEL    = 4'd5;
   localparam logic [3:0] OP_EV_DONE   = 4'd6;
   localparam logic [3:0] OP_REL_DONE  = 4'd7;

   typedef struct packed {
      logic        cmd;
      logic [31:0] file_id;
      logic [31:0] block_index;
      logic [31:0] device_block;
      logic        unmapped;
      logic [5:0]  release_slot;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [5:0]  slot;
      logic [31:0] fill_block;
      logic        evicted;
      logic [15:0] refs_after;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
   } ctl_cmd_type;

   typedef struct packed {
      logic match;
      logic scan_done;
      logic need_evict;
      logic out_free;
   } ctl_status_type;

endpackage

// ===== hdl/refcounted_lru_block_buffer_cache_top.sv =====
// Channel  Ports                                  Direction
// req      req_valid, req_ready, req_payload      in   (get or put)
// rsp      rsp_valid, rsp_ready, rsp_payload      out  (one per transaction)
//
// A get scans the key memory one slot a cycle over the slots in use; a hit,
// a put and an eviction each read the slot's count and links before they
// answer. The next transaction can be accepted in the cycle right after the
// last one. The result sits in an output register; the block holds a finished
// item until it is free. Reset is synchronous and needs no clearing pass.
module refcounted_lru_block_buffer_cache_top #(
   parameter int NUM_SLOTS = 64,
   parameter int REF_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lrubc_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lrubc_pkg::rsp_type rsp_payload
);

   lrubc_pkg::ctl_cmd_type    ctl;
   lrubc_pkg::ctl_status_type sts;

   lrubc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_cmd(req_payload.cmd), .req_ready(req_ready), .sts(sts), .ctl(ctl));

   lrubc_datapath #(.NUM_SLOTS(NUM_SLOTS), .REF_BITS(REF_BITS)) u_datapath (
      .clock(clock), .reset(reset), .req_payload(req_payload), .ctl(ctl),
      .sts(sts), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload));

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a transaction without leaving idle");

   a_filled_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == lrubc_pkg::ST_FILLED)
      |-> (rsp_payload.refs_after == 16'd1 && rsp_payload.fill_block != 32'd0))
      else $error("filled miss with bad count or fill address");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == lrubc_pkg::ST_IDLE)
      |-> (rsp_payload.refs_after == 16'd0 && !rsp_payload.evicted))
      else $error("released idle slot reports references");

endmodule

// ===== hdl/lrubc_ram.sv =====
module lrubc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== hdl/lrubc_ctrl.sv =====
module lrubc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_cmd,
   output logic                    req_ready,
   input  lrubc_pkg::ctl_status_type sts,
   output lrubc_pkg::ctl_cmd_type  ctl
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_HIT_RD = 4'd2;
   localparam logic [3:0] S_HIT_EX = 4'd3;
   localparam logic [3:0] S_MISS   = 4'd4;
   localparam logic [3:0] S_EV_RD  = 4'd5;
   localparam logic [3:0] S_EV_EX  = 4'd6;
   localparam logic [3:0] S_REL_RD = 4'd7;
   localparam logic [3:0] S_REL_EX = 4'd8;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl.op   = lrubc_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.op   = lrubc_pkg::OP_LOAD;
               state_in = (req_cmd == lrubc_pkg::CMD_PUT) ? S_REL_RD : S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.op = lrubc_pkg::OP_SCAN;
            if (sts.match) begin
               state_in = S_HIT_RD;
            end else if (sts.scan_done) begin
               state_in = S_MISS;
            end
         end
         S_HIT_RD: state_in = S_HIT_EX;
         S_HIT_EX: begin
            if (sts.out_free) begin
               ctl.op   = lrubc_pkg::OP_HIT_DONE;
               state_in = S_IDLE;
            end
         end
         S_MISS: begin
            if (sts.need_evict) begin
               ctl.op   = lrubc_pkg::OP_EV_SEL;
               state_in = S_EV_RD;
            end else if (sts.out_free) begin
               ctl.op   = lrubc_pkg::OP_MISS_DONE;
               state_in = S_IDLE;
            end
         end
         S_EV_RD: state_in = S_EV_EX;
         S_EV_EX: begin
            if (sts.out_free) begin
               ctl.op   = lrubc_pkg::OP_EV_DONE;
               state_in = S_IDLE;
            end
         end
         S_REL_RD: state_in = S_REL_EX;
         S_REL_EX: begin
            if (sts.out_free) begin
               ctl.op   = lrubc_pkg::OP_REL_DONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/lrubc_datapath.sv =====
module lrubc_datapath #(
   parameter int NUM_SLOTS = 64,
   parameter int REF_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lrubc_pkg::req_type        req_payload,
   input  lrubc_pkg::ctl_cmd_type    ctl,
   output lrubc_pkg::ctl_status_type sts,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lrubc_pkg::rsp_type        rsp_payload
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int CW = $clog2(NUM_SLOTS + 1);

   lrubc_pkg::req_type req_ff, req_in;
   lrubc_pkg::rsp_type rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [SW-1:0]      pend_slot_ff, pend_slot_in;
   logic               pend_ff, pend_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic [CW-1:0]      fresh_ff, fresh_in;
   logic [SW-1:0]      head_ff, head_in;
   logic [SW-1:0]      tail_ff, tail_in;
   logic               empty_ff, empty_in;

   logic               key_we, ref_we, nxt_we, prv_we;
   logic [SW-1:0]      key_wa, ref_wa, nxt_wa, prv_wa;
   logic [63:0]        key_wd, key_rd;
   logic [REF_BITS-1:0] ref_wd, ref_rd;
   logic [SW-1:0]      nxt_wd, nxt_rd, prv_wd, prv_rd;

   logic               match, scan_done, fresh_full, rel_bad;
   logic [REF_BITS-1:0] ref_dec;

   lrubc_ram #(.WIDTH(64), .DEPTH(NUM_SLOTS)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
      .rd_addr(SW'(scan_ff)), .rd_data(key_rd));
   lrubc_ram #(.WIDTH(REF_BITS), .DEPTH(NUM_SLOTS)) u_ref_ram (
      .clock(clock), .wr_en(ref_we), .wr_addr(ref_wa), .wr_data(ref_wd),
      .rd_addr(slot_ff), .rd_data(ref_rd));
   lrubc_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_next_ram (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(slot_ff), .rd_data(nxt_rd));
   lrubc_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_prev_ram (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_addr(slot_ff), .rd_data(prv_rd));

   assign match      = pend_ff && (key_rd == {req_ff.file_id, req_ff.block_index});
   assign scan_done  = (scan_ff == fresh_ff);
   assign fresh_full = (fresh_ff == CW'(NUM_SLOTS));
   // slots are taken in index order and never dropped, so valid means below the fill count
   assign rel_bad    = (32'(req_ff.release_slot) >= 32'(NUM_SLOTS))
                    || (32'(req_ff.release_slot) >= 32'(fresh_ff))
                    || (ref_rd == '0);
   assign ref_dec    = ref_rd - REF_BITS'(1);

   assign sts.match      = match;
   assign sts.scan_done  = scan_done;
   assign sts.need_evict = !req_ff.unmapped && (req_ff.device_block != '0)
                        && fresh_full && !empty_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      slot_in      = slot_ff;
      pend_slot_in = pend_slot_ff;
      pend_in      = pend_ff;
      scan_in      = scan_ff;
      fresh_in     = fresh_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      empty_in     = empty_ff;
      key_we = 1'b0; key_wa = slot_ff; key_wd = {req_ff.file_id, req_ff.block_index};
      ref_we = 1'b0; ref_wa = slot_ff; ref_wd = REF_BITS'(1);
      nxt_we = 1'b0; nxt_wa = slot_ff; nxt_wd = head_ff;
      prv_we = 1'b0; prv_wa = head_ff; prv_wd = slot_ff;

      case (ctl.op)
         lrubc_pkg::OP_LOAD: begin
            req_in  = req_payload;
            scan_in = '0;
            pend_in = 1'b0;
            slot_in = SW'(req_payload.release_slot);
         end
         lrubc_pkg::OP_SCAN: begin
            if (match) begin
               slot_in = pend_slot_ff;
            end else if (!scan_done) begin
               pend_in      = 1'b1;
               pend_slot_in = SW'(scan_ff);
               scan_in      = scan_ff + CW'(1);
            end
         end
         lrubc_pkg::OP_HIT_DONE: begin
            rsp_valid_in      = 1'b1;
            rsp_in            = '0;
            rsp_in.slot       = 6'(slot_ff);
            if (&ref_rd) begin
               rsp_in.status     = lrubc_pkg::ST_REFFULL;
               rsp_in.refs_after = 16'(ref_rd);
            end else begin
               rsp_in.status     = lrubc_pkg::ST_HIT;
               rsp_in.refs_after = 16'(ref_rd + REF_BITS'(1));
               ref_we = 1'b1;
               ref_wd = ref_rd + REF_BITS'(1);
               if (ref_rd == '0 && !empty_ff) begin
                  // idle slot leaves the recency list
                  if (head_ff == slot_ff && tail_ff == slot_ff) begin
                     empty_in = 1'b1;
                  end else if (head_ff == slot_ff) begin
                     head_in = nxt_rd;
                  end else if (tail_ff == slot_ff) begin
                     tail_in = prv_rd;
                  end else begin
                     nxt_we = 1'b1; nxt_wa = prv_rd; nxt_wd = nxt_rd;
                     prv_we = 1'b1; prv_wa = nxt_rd; prv_wd = prv_rd;
                  end
               end
            end
         end
         lrubc_pkg::OP_MISS_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            if (req_ff.unmapped) begin
               rsp_in.status = lrubc_pkg::ST_UNMAPPED;
            end else if (req_ff.device_block == '0) begin
               rsp_in.status = lrubc_pkg::ST_ZERO;
            end else if (!fresh_full) begin
               key_we = 1'b1; key_wa = SW'(fresh_ff);
               ref_we = 1'b1; ref_wa = SW'(fresh_ff);
               fresh_in          = fresh_ff + CW'(1);
               rsp_in.status     = lrubc_pkg::ST_FILLED;
               rsp_in.slot       = 6'(fresh_ff);
               rsp_in.fill_block = req_ff.device_block;
               rsp_in.refs_after = 16'd1;
            end else begin
               rsp_in.status = lrubc_pkg::ST_EXHAUSTED;
            end
         end
         lrubc_pkg::OP_EV_SEL: begin
            slot_in = tail_ff;
         end
         lrubc_pkg::OP_EV_DONE: begin
            if (head_ff == tail_ff) begin
               empty_in = 1'b1;
            end else begin
               tail_in = prv_rd;
            end
            key_we = 1'b1;
            ref_we = 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_in.status     = lrubc_pkg::ST_FILLED;
            rsp_in.slot       = 6'(slot_ff);
            rsp_in.fill_block = req_ff.device_block;
            rsp_in.evicted    = 1'b1;
            rsp_in.refs_after = 16'd1;
         end
         lrubc_pkg::OP_REL_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            rsp_in.slot  = req_ff.release_slot;
            if (rel_bad) begin
               rsp_in.status = lrubc_pkg::ST_BADREL;
            end else begin
               ref_we = 1'b1;
               ref_wd = ref_dec;
               if (ref_dec == '0) begin
                  rsp_in.status = lrubc_pkg::ST_IDLE;
                  head_in = slot_ff;
                  if (empty_ff) begin
                     tail_in  = slot_ff;
                     empty_in = 1'b0;
                  end else begin
                     nxt_we = 1'b1;
                     prv_we = 1'b1;
                  end
               end else begin
                  rsp_in.status     = lrubc_pkg::ST_HELD;
                  rsp_in.refs_after = 16'(ref_dec);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fresh_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         pend_ff      <= 1'b0;
         scan_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         fresh_ff     <= fresh_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         pend_ff      <= pend_in;
         scan_ff      <= scan_in;
      end
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      slot_ff      <= slot_in;
      pend_slot_ff <= pend_slot_in;
   end

endmodule
